// ===== design/kvs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and fixed-point constants of the key velocity sensor.
package kvs_pkg;

	// Fixed field and register widths.
	localparam int LEVEL_W   = 10;
	localparam int TC_W      = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int EVENT_W   = 3;
	localparam int CLASS_W   = 2;
	localparam int VEL_W     = 16;

	// Velocity arithmetic widths.
	localparam int X_W      = 20;           // dt * 2^16 / T, below 12 * 2^16
	localparam int FRAC_W   = 16;           // fractional part of x
	localparam int N_W      = X_W - FRAC_W; // integer part of x
	localparam int MAG_W    = 31;           // magnitude of a Q30 series term
	localparam int SUM_W    = 33;           // signed Q30 series sum
	localparam int ACC_W    = 31;           // non-negative Q30 accumulator
	localparam int INV_W    = 29;           // width of the e^-1 constant
	localparam int EPROD_W  = ACC_W + INV_W;
	localparam int TPROD_W  = MAG_W + FRAC_W;
	localparam int K_W      = 5;
	localparam int TERMS    = 16;
	localparam int RND_W    = 32;
	localparam int RND_SH   = 14;

	// Q30 constants. INV_E is the 17-term truncated series for e^-1.
	localparam logic [MAG_W-1:0]   Q30_ONE  = 31'h4000_0000;
	localparam logic [INV_W-1:0]   INV_E    = 29'd395007543;
	localparam logic [EPROD_W-1:0] HALF_Q30 = 60'h000_0000_2000_0000;
	localparam logic [RND_W-1:0]   HALF_Q14 = 32'h0000_2000;
	localparam logic [VEL_W-1:0]   VEL_MAX  = 16'hFFFF;

	// Shared divider widths.
	localparam int DIV_W     = 32;
	localparam int REM_W     = 16;
	localparam int DIV_CNT_W = 6;

	typedef enum logic [EVENT_W-1:0] {
		EV_NONE     = 3'd0,
		EV_TRAVEL   = 3'd1,
		EV_NOTE_ON  = 3'd2,
		EV_NOTE_OFF = 3'd3,
		EV_SUSTAIN  = 3'd4
	} event_t;

	typedef enum logic [CLASS_W-1:0] {
		CLS_UNPRESSED = 2'd0,
		CLS_TRAVEL    = 2'd1,
		CLS_PRESSED   = 2'd2
	} class_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_UNPRESSED  = 2'd0,
		REG_PRESSED    = 2'd1,
		REG_TOLERANCE  = 2'd2,
		REG_TIME_CONST = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_MUL,
		ST_KDIV,
		ST_EMUL,
		ST_ROUND,
		ST_DONE
	} state_t;

	// Request to the shared divider: remainder seed, dividend bits shifted
	// in from the top, number of quotient bits and divisor.
	typedef struct packed {
		logic                 start;
		logic [REM_W-1:0]     rem_init;
		logic [DIV_W-1:0]     dividend;
		logic [DIV_CNT_W-1:0] count;
		logic [REM_W-1:0]     divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== design/kvs_div.sv =====
`timescale 1ns / 1ps
// Shared restoring divider: one quotient bit per clock cycle.
module kvs_div (
	input  logic              clk,
	input  logic              arst_n,
	input  kvs_pkg::div_req_t req,
	output kvs_pkg::div_rsp_t rsp
);

	logic                          busy_q;
	logic                          done_q;
	logic [kvs_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [kvs_pkg::REM_W-1:0]     rem_q;
	logic [kvs_pkg::REM_W-1:0]     div_q;
	logic [kvs_pkg::DIV_W-1:0]     shf_q;

	logic [kvs_pkg::REM_W:0]       trial;
	logic [kvs_pkg::REM_W:0]       diff;
	logic                          ge;
	logic [kvs_pkg::REM_W-1:0]     rem_nxt;

	// One trial subtraction of the divisor from the shifted remainder.
	always_comb begin
		trial   = {rem_q, shf_q[kvs_pkg::DIV_W-1]};
		ge      = trial >= {1'b0, div_q};
		diff    = trial - {1'b0, div_q};
		rem_nxt = ge ? diff[kvs_pkg::REM_W-1:0] : trial[kvs_pkg::REM_W-1:0];
	end

	// Iteration count and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= req.count;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == kvs_pkg::DIV_CNT_W'(1));
			busy_q <= (cnt_q != kvs_pkg::DIV_CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// Remainder and the dividend shift line; quotient bits enter at the bottom.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem_init;
			div_q <= req.divisor;
			shf_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			shf_q <= {shf_q[kvs_pkg::DIV_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = shf_q;

endmodule

// ===== design/key_velocity_sensor_top.sv =====
`timescale 1ns / 1ps
// Top level of the key velocity sensor: classification, sequencer and output register.
//
//  Channel  Direction  Handshake            Payload
//  in       request    in_valid / in_stall  sample_level, time_ms, sustain_held
//  out      result     out_valid/ out_stall event_res, key_class, strike_velocity
//  cfg      write      cfg_write            cfg_index, cfg_data
//
// A request without a strike goes from IDLE to DONE, which loads the output register;
// a strike past the decay cutoff passes through PREP on the way.
// A strike runs K (at most 16) series terms, each one multiply and a pass of the shared
// divider for a 32-bit quotient, and then n (at most 11) e^-1 products.
// in_stall is high from acceptance until the result is in the output register.
// The next request is taken while a result waits in the output register.
// Reset is asynchronous, active low, and restores the configuration, the key state and
// the handshake registers to their defaults.
module key_velocity_sensor_top #(
	parameter int SAMPLE_BITS = 10,
	parameter int TIME_BITS   = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [SAMPLE_BITS-1:0]              sample_level,
	input  logic [TIME_BITS-1:0]                time_ms,
	input  logic                                sustain_held,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [kvs_pkg::EVENT_W-1:0]         event_res,
	output logic [kvs_pkg::CLASS_W-1:0]         key_class,
	output logic [kvs_pkg::VEL_W-1:0]           strike_velocity,
	input  logic                                cfg_write,
	input  logic [kvs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [kvs_pkg::CFG_W-1:0]           cfg_data
);

	localparam int CMP_W = (SAMPLE_BITS > kvs_pkg::LEVEL_W + 1) ?
		SAMPLE_BITS : kvs_pkg::LEVEL_W + 1;
	localparam int DT_W  = (TIME_BITS > kvs_pkg::X_W) ? TIME_BITS : kvs_pkg::X_W;

	kvs_pkg::state_t state_q, state_nxt;

	// Configuration registers.
	logic [kvs_pkg::LEVEL_W-1:0] unp_q, prs_q, tol_q;
	logic [kvs_pkg::TC_W-1:0]    tc_q;

	// Key state.
	kvs_pkg::class_t             cls_q;
	logic [TIME_BITS-1:0]        travel_q;
	logic [kvs_pkg::VEL_W-1:0]   vel_q;
	kvs_pkg::event_t             ev_q;

	// Velocity working registers.
	logic [TIME_BITS-1:0]        dt_q;
	logic [kvs_pkg::FRAC_W-1:0]  frac_q;
	logic [kvs_pkg::N_W-1:0]     n_q;
	logic [kvs_pkg::MAG_W-1:0]   mag_q;
	logic signed [kvs_pkg::SUM_W-1:0] sum_q;
	logic [kvs_pkg::ACC_W-1:0]   acc_q;
	logic [kvs_pkg::K_W-1:0]     k_q;

	// Output register.
	logic                        out_valid_q;
	kvs_pkg::event_t             out_ev_q;
	kvs_pkg::class_t             out_cls_q;
	logic [kvs_pkg::VEL_W-1:0]   out_vel_q;

	kvs_pkg::div_req_t           div_req;
	kvs_pkg::div_rsp_t           div_rsp;

	logic                        in_take;
	logic                        out_load;
	logic                        is_unpressed, is_pressed;
	logic [kvs_pkg::LEVEL_W:0]   lo_bound;
	logic [kvs_pkg::LEVEL_W-1:0] hi_bound;
	kvs_pkg::class_t             cls_new;
	kvs_pkg::event_t             ev_new;
	logic                        strike;

	logic [kvs_pkg::TC_W-1:0]    teff;
	logic [kvs_pkg::X_W-1:0]     t12;
	logic [kvs_pkg::X_W-1:0]     dt20;
	logic                        dt_big;
	logic [kvs_pkg::TPROD_W-1:0] tprod;
	logic [kvs_pkg::MAG_W-1:0]   q_mag;
	logic signed [kvs_pkg::SUM_W-1:0] term_ext, sum_nxt;
	logic                        last_term;
	logic [kvs_pkg::EPROD_W-1:0] eprod;
	logic [kvs_pkg::RND_W-1:0]   rnd;
	logic [kvs_pkg::RND_W-kvs_pkg::RND_SH-1:0] rnd_sh;
	logic [kvs_pkg::VEL_W-1:0]   vel_rnd;

	kvs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Classify the incoming sample against the two tolerance bands.
	always_comb begin
		lo_bound     = {1'b0, unp_q} + {1'b0, tol_q};
		hi_bound     = prs_q - tol_q;
		is_unpressed = CMP_W'(sample_level) < CMP_W'(lo_bound);
		is_pressed   = (tol_q > prs_q) || (CMP_W'(sample_level) > CMP_W'(hi_bound));
		if (is_unpressed) begin
			cls_new = kvs_pkg::CLS_UNPRESSED;
		end else if (is_pressed) begin
			cls_new = kvs_pkg::CLS_PRESSED;
		end else begin
			cls_new = kvs_pkg::CLS_TRAVEL;
		end
		ev_new = kvs_pkg::EV_NONE;
		if (cls_new != cls_q) begin
			case (cls_new)
				kvs_pkg::CLS_TRAVEL:  ev_new = kvs_pkg::EV_TRAVEL;
				kvs_pkg::CLS_PRESSED: ev_new = kvs_pkg::EV_NOTE_ON;
				default:              ev_new = sustain_held ? kvs_pkg::EV_SUSTAIN :
					kvs_pkg::EV_NOTE_OFF;
			endcase
		end
		strike = (ev_new == kvs_pkg::EV_NOTE_ON);
	end

	// Time-constant bound and the elapsed-time slice fed to the divider.
	always_comb begin
		teff   = (tc_q == '0) ? kvs_pkg::TC_W'(1) : tc_q;
		t12    = (kvs_pkg::X_W'(teff) << 3) + (kvs_pkg::X_W'(teff) << 2);
		dt_big = DT_W'(dt_q) >= DT_W'(t12);
		dt20   = kvs_pkg::X_W'(dt_q);
	end

	// Series term product, next sum and the e^-1 step.
	always_comb begin
		tprod     = kvs_pkg::TPROD_W'(mag_q) * kvs_pkg::TPROD_W'(frac_q);
		q_mag     = div_rsp.quotient[kvs_pkg::MAG_W-1:0];
		term_ext  = $signed({2'b00, q_mag});
		sum_nxt   = k_q[0] ? (sum_q - term_ext) : (sum_q + term_ext);
		last_term = (k_q == kvs_pkg::K_W'(kvs_pkg::TERMS)) || (q_mag == '0);
		eprod     = kvs_pkg::EPROD_W'(acc_q) * kvs_pkg::EPROD_W'(kvs_pkg::INV_E)
			+ kvs_pkg::HALF_Q30;
		rnd       = kvs_pkg::RND_W'(acc_q) + kvs_pkg::HALF_Q14;
		rnd_sh    = rnd[kvs_pkg::RND_W-1:kvs_pkg::RND_SH];
		vel_rnd   = (rnd_sh > (kvs_pkg::RND_W-kvs_pkg::RND_SH)'(kvs_pkg::VEL_MAX)) ?
			kvs_pkg::VEL_MAX : rnd_sh[kvs_pkg::VEL_W-1:0];
	end

	// Sequencer next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			kvs_pkg::ST_IDLE:  if (in_valid) begin
				state_nxt = strike ? kvs_pkg::ST_PREP : kvs_pkg::ST_DONE;
			end
			kvs_pkg::ST_PREP:  state_nxt = dt_big ? kvs_pkg::ST_DONE : kvs_pkg::ST_DIV;
			kvs_pkg::ST_DIV:   if (div_rsp.done) begin
				state_nxt = kvs_pkg::ST_MUL;
			end
			kvs_pkg::ST_MUL:   state_nxt = kvs_pkg::ST_KDIV;
			kvs_pkg::ST_KDIV:  if (div_rsp.done) begin
				state_nxt = last_term ? kvs_pkg::ST_EMUL : kvs_pkg::ST_MUL;
			end
			kvs_pkg::ST_EMUL:  if (n_q == '0) begin
				state_nxt = kvs_pkg::ST_ROUND;
			end
			kvs_pkg::ST_ROUND: state_nxt = kvs_pkg::ST_DONE;
			kvs_pkg::ST_DONE:  if (!out_valid_q || !out_stall) begin
				state_nxt = kvs_pkg::ST_IDLE;
			end
			default:           state_nxt = kvs_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake and divider requests.
	always_comb begin
		in_stall         = 1'b1;
		out_load         = 1'b0;
		div_req.start    = 1'b0;
		div_req.rem_init = '0;
		div_req.dividend = {1'b0, tprod[kvs_pkg::TPROD_W-1:kvs_pkg::FRAC_W]};
		div_req.count    = kvs_pkg::DIV_CNT_W'(kvs_pkg::DIV_W);
		div_req.divisor  = kvs_pkg::REM_W'(k_q);
		case (state_q)
			kvs_pkg::ST_IDLE: in_stall = 1'b0;
			kvs_pkg::ST_PREP: begin
				div_req.start    = !dt_big;
				div_req.rem_init = dt20[kvs_pkg::X_W-1:kvs_pkg::X_W-kvs_pkg::REM_W];
				div_req.dividend = {dt20[kvs_pkg::X_W-kvs_pkg::REM_W-1:0],
					{(kvs_pkg::DIV_W-kvs_pkg::X_W+kvs_pkg::REM_W){1'b0}}};
				div_req.count    = kvs_pkg::DIV_CNT_W'(kvs_pkg::X_W);
				div_req.divisor  = teff;
			end
			kvs_pkg::ST_MUL:  div_req.start = 1'b1;
			kvs_pkg::ST_DONE: out_load = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	assign in_take = in_valid && !in_stall;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kvs_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Configuration writes; unknown indexes cannot occur on a two-bit index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unp_q <= kvs_pkg::LEVEL_W'(0);
			prs_q <= kvs_pkg::LEVEL_W'(1023);
			tol_q <= kvs_pkg::LEVEL_W'(100);
			tc_q  <= kvs_pkg::TC_W'(100);
		end else if (cfg_write) begin
			case (kvs_pkg::reg_idx_t'(cfg_index))
				kvs_pkg::REG_UNPRESSED:  unp_q <= cfg_data[kvs_pkg::LEVEL_W-1:0];
				kvs_pkg::REG_PRESSED:    prs_q <= cfg_data[kvs_pkg::LEVEL_W-1:0];
				kvs_pkg::REG_TOLERANCE:  tol_q <= cfg_data[kvs_pkg::LEVEL_W-1:0];
				kvs_pkg::REG_TIME_CONST: tc_q  <= cfg_data[kvs_pkg::TC_W-1:0];
				default: ;
			endcase
		end
	end

	// Key state: class, travel timestamp, event and last velocity.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cls_q    <= kvs_pkg::CLS_UNPRESSED;
			travel_q <= '0;
			vel_q    <= '0;
			ev_q     <= kvs_pkg::EV_NONE;
		end else begin
			if (in_take) begin
				cls_q <= cls_new;
				ev_q  <= ev_new;
				if (ev_new == kvs_pkg::EV_TRAVEL) begin
					travel_q <= time_ms;
				end
			end
			if (state_q == kvs_pkg::ST_PREP && dt_big) begin
				vel_q <= '0;
			end else if (state_q == kvs_pkg::ST_ROUND) begin
				vel_q <= vel_rnd;
			end
		end
	end

	// Velocity datapath: elapsed time, series terms and e^-1 products.
	always_ff @(posedge clk) begin
		if (in_take) begin
			dt_q <= time_ms - travel_q;
		end
		case (state_q)
			kvs_pkg::ST_DIV: if (div_rsp.done) begin
				n_q    <= div_rsp.quotient[kvs_pkg::X_W-1:kvs_pkg::FRAC_W];
				frac_q <= div_rsp.quotient[kvs_pkg::FRAC_W-1:0];
				mag_q  <= kvs_pkg::Q30_ONE;
				sum_q  <= $signed(kvs_pkg::SUM_W'(kvs_pkg::Q30_ONE));
				k_q    <= kvs_pkg::K_W'(1);
			end
			kvs_pkg::ST_KDIV: if (div_rsp.done) begin
				mag_q <= q_mag;
				sum_q <= sum_nxt;
				k_q   <= k_q + 1'b1;
				acc_q <= sum_nxt[kvs_pkg::SUM_W-1] ? '0 : sum_nxt[kvs_pkg::ACC_W-1:0];
			end
			kvs_pkg::ST_EMUL: if (n_q != '0) begin
				acc_q <= kvs_pkg::ACC_W'(eprod[kvs_pkg::EPROD_W-1:30]);
				n_q   <= n_q - 1'b1;
			end
			default: ;
		endcase
	end

	// Output register parts the result side from the request side.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ev_q  <= ev_q;
			out_cls_q <= cls_q;
			out_vel_q <= vel_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign event_res       = out_ev_q;
	assign key_class       = out_cls_q;
	assign strike_velocity = out_vel_q;

endmodule
